FILE: design/uri_pc_pkg.sv
// ----------------------------------------------------------------------------
// URI percent codec package
// Shared types, codes and character tables for the percent codec.
// ----------------------------------------------------------------------------
`default_nettype none

package uri_pc_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SAFE_CLASS = 1'b1;
  localparam int unsigned CfgDataW = 3;

  // Direction codes.
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Safe class codes; the two unused codes behave like the empty set.
  localparam logic [2:0] SAFE_NONE   = 3'd0;
  localparam logic [2:0] SAFE_USER   = 3'd1;
  localparam logic [2:0] SAFE_HOST   = 3'd2;
  localparam logic [2:0] SAFE_PATH   = 3'd3;
  localparam logic [2:0] SAFE_QUERY  = 3'd4;
  localparam logic [2:0] SAFE_OPTION = 3'd5;

  // Decode progress codes.
  localparam logic [1:0] PEND_IDLE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  localparam logic [7:0] CHAR_PCT = 8'h25;

  // Upper-case hex digit characters.
  localparam logic [15:0][7:0] HEX_UPPER = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // One group of up to three result bytes caused by one input item.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } grp_t;

  // Value of a hex digit character; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

  // Letters, digits and the four unreserved marks.
  function automatic logic is_unreserved(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h2e ||
           c == 8'h5f || c == 8'h7e;
  endfunction

  // Sub-delimiters: ! $ & ' ( ) * + , ; =
  function automatic logic is_subdelim(input logic [7:0] c);
    return c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 ||
           c == 8'h28 || c == 8'h29 || c == 8'h2a || c == 8'h2b ||
           c == 8'h2c || c == 8'h3b || c == 8'h3d;
  endfunction

  // Whether a byte passes unescaped under the given safe class.
  function automatic logic is_safe(input logic [7:0] c, input logic [2:0] cls);
    logic s;
    s = 1'b0;
    if (cls >= SAFE_USER && cls <= SAFE_OPTION) begin
      if (c == 8'h00 || is_unreserved(c)) begin
        s = 1'b1;
      end else if (cls == SAFE_OPTION) begin
        // Sub-delimiters without & and =, plus : @ / ?
        s = (is_subdelim(c) && c != 8'h26 && c != 8'h3d) ||
            c == 8'h3a || c == 8'h40 || c == 8'h2f || c == 8'h3f;
      end else if (is_subdelim(c)) begin
        s = 1'b1;
      end else if (cls == SAFE_HOST) begin
        s = (c == 8'h3a);
      end else if (cls == SAFE_PATH) begin
        s = c == 8'h3a || c == 8'h40 || c == 8'h2f;
      end else if (cls == SAFE_QUERY) begin
        s = c == 8'h3a || c == 8'h40 || c == 8'h2f || c == 8'h3f;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/uri_pc_step.sv
// ----------------------------------------------------------------------------
// URI percent codec conversion stage
// Input register, decode progress state and the per-item conversion logic.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_pc_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              dir_i,
  input  logic [2:0]        safe_class_i,
  input  logic              state_clr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              grp_valid_o,
  input  logic              grp_ready_i,
  output uri_pc_pkg::grp_t  grp_o
);
  import uri_pc_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic [1:0] pend_q, pend_d;
  logic [7:0] held_q, held_d;
  logic       advance;
  logic       load;
  grp_t       grp;
  logic [4:0] h1;
  logic [4:0] h2;

  // The input register takes a beat whenever its item moves on or it is empty.
  assign advance    = s1_valid_q && grp_ready_i;
  assign in_ready_o = !s1_valid_q || grp_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign s1_valid_d = load ? 1'b1 : (advance ? 1'b0 : s1_valid_q);

  assign h1 = hex_value(held_q);
  assign h2 = hex_value(s1_byte_q);

  // Conversion of the held item into a result group and the next decode state.
  always_comb begin
    grp       = '0;
    grp.last  = s1_last_q;
    pend_d    = pend_q;
    held_d    = held_q;
    if (dir_i == DIR_ENCODE) begin
      if (is_safe(s1_byte_q, safe_class_i)) begin
        grp.cnt      = 2'd1;
        grp.bytes[0] = s1_byte_q;
      end else begin
        grp.cnt      = 2'd3;
        grp.bytes[0] = CHAR_PCT;
        grp.bytes[1] = HEX_UPPER[s1_byte_q[7:4]];
        grp.bytes[2] = HEX_UPPER[s1_byte_q[3:0]];
      end
    end else begin
      unique case (pend_q)
        PEND_PCT: begin
          if (s1_last_q) begin
            grp.cnt      = 2'd2;
            grp.bytes[0] = CHAR_PCT;
            grp.bytes[1] = s1_byte_q;
            pend_d       = PEND_IDLE;
            held_d       = '0;
          end else begin
            held_d = s1_byte_q;
            pend_d = PEND_DIGIT;
          end
        end
        PEND_DIGIT: begin
          if (!h1[4] && !h2[4]) begin
            grp.cnt      = 2'd1;
            grp.bytes[0] = {h1[3:0], h2[3:0]};
          end else begin
            grp.cnt      = 2'd3;
            grp.bytes[0] = CHAR_PCT;
            grp.bytes[1] = held_q;
            grp.bytes[2] = s1_byte_q;
          end
          pend_d = PEND_IDLE;
          held_d = '0;
        end
        default: begin
          // Idle, and the unreachable fourth code.
          pend_d = PEND_IDLE;
          if (s1_byte_q == CHAR_PCT) begin
            if (s1_last_q) begin
              grp.cnt      = 2'd1;
              grp.bytes[0] = CHAR_PCT;
            end else begin
              pend_d = PEND_PCT;
            end
          end else begin
            grp.cnt      = 2'd1;
            grp.bytes[0] = s1_byte_q;
          end
        end
      endcase
    end
  end

  assign grp_valid_o = s1_valid_q && (grp.cnt != 2'd0);
  assign grp_o       = grp;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= PEND_IDLE;
      held_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (state_clr_i) begin
        pend_q <= PEND_IDLE;
        held_q <= '0;
      end else if (advance) begin
        pend_q <= pend_d;
        held_q <= held_d;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/uri_pc_serial.sv
// ----------------------------------------------------------------------------
// URI percent codec result register
// Holds one result group and sends its bytes out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_pc_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              grp_valid_i,
  output logic              grp_ready_o,
  input  uri_pc_pkg::grp_t  grp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import uri_pc_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  grp_t       grp_q;
  logic       final_beat;
  logic       take;
  logic       load;

  // The group is done when its final byte is taken.
  assign final_beat  = (idx_q == grp_q.cnt - 2'd1);
  assign take        = valid_q && out_ready_i;
  assign grp_ready_o = !valid_q || (out_ready_i && final_beat);
  assign load        = grp_valid_i && grp_ready_o;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (final_beat) begin
        valid_d = 1'b0;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Result group payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

  // Output beat selection.
  assign out_valid_o = valid_q;
  assign out_byte_o  = (idx_q == 2'd0) ? grp_q.bytes[0] :
                       (idx_q == 2'd1) ? grp_q.bytes[1] : grp_q.bytes[2];
  assign out_last_o  = grp_q.last && final_beat;

endmodule

`default_nettype wire

FILE: design/uri_percent_codec_unit.sv
// ----------------------------------------------------------------------------
// URI percent codec
// Streams bytes through percent-escape decoding or encoding.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  in        in_valid_i / in_ready_o    in_byte_i, in_last_i
//  out       out_valid_o / out_ready_i  out_byte_o, out_last_o
//  cfg       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
//  An accepted beat waits in the input register, then its group of up to
//  three result bytes, if any, loads into the result register, which sends
//  one byte per cycle while out_ready_i is high. A passed byte gives one
//  result byte, an escaped byte three, and a held decode byte none.
//  A stalled output holds both registers and drops in_ready_o once they fill.
//  Reset clears the configuration, the decode progress and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_codec_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uri_pc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [uri_pc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);
  import uri_pc_pkg::*;

  logic       dir_q;
  logic [2:0] safe_class_q;
  logic       dir_wr;
  logic       grp_valid;
  logic       grp_ready;
  grp_t       grp;

  assign dir_wr = cfg_we_i && (cfg_idx_i == REG_DIRECTION);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q        <= DIR_DECODE;
      safe_class_q <= SAFE_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIRECTION:  dir_q        <= cfg_wdata_i[0];
        REG_SAFE_CLASS: safe_class_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Conversion stage.
  uri_pc_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_q),
    .safe_class_i (safe_class_q),
    .state_clr_i  (dir_wr),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .grp_valid_o  (grp_valid),
    .grp_ready_i  (grp_ready),
    .grp_o        (grp)
  );

  // Result register and output serializer.
  uri_pc_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .grp_i       (grp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

FILE: verif/uri_percent_codec_unit_test.sv
// ----------------------------------------------------------------------------
// URI percent codec unit test
// Drives byte strings through the codec in decode and encode mode under every
// safe class, predicts each result beat in a scoreboard, and compares them in
// order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_codec_unit_test;
  import uri_pc_pkg::*;

  // Safe class codes without a name in the package; both escape everything.
  localparam logic [2:0] SAFE_SPARE6 = 3'd6;
  localparam logic [2:0] SAFE_SPARE7 = 3'd7;

  // Cycles to let a beat that causes no result work its way through.
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS      = 25;
  localparam int unsigned PHASE_COUNT      = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } char_beat_t;

  typedef logic [7:0] byte_q_t[$];

  // Predicts the result beats of the codec and checks them in order.
  class codec_scoreboard;
    logic                dir;
    logic [2:0]          cls;
    logic [1:0]          pend;
    logic [7:0]          held;
    char_beat_t          expected_chars[$];
    int unsigned         fail_count;
    int unsigned         beats_in;
    int unsigned         beats_out;
    int unsigned         writes;

    function new();
      dir        = DIR_DECODE;
      cls        = SAFE_NONE;
      pend       = PEND_IDLE;
      held       = 8'h00;
      fail_count = 0;
      beats_in   = 0;
      beats_out  = 0;
      writes     = 0;
    endfunction

    task report_mismatch(input string msg);
      fail_count++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    // A write to the direction register drops any half-read escape.
    function void apply_setting(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
      writes++;
      if (idx == REG_DIRECTION) begin
        dir  = val[0];
        pend = PEND_IDLE;
        held = 8'h00;
      end else if (idx == REG_SAFE_CLASS) begin
        cls = val;
      end
    endfunction

    // Returns 1 and the nibble value when c is a hex digit of either case.
    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      logic [7:0] folded;
      folded = c | 8'h20;
      v = 4'h0;
      if (c >= "0" && c <= "9") begin
        v = c[3:0];
        return 1'b1;
      end
      if (folded >= "a" && folded <= "f") begin
        v = folded[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Whether a byte goes out unescaped under the current safe class.
    function bit passes_plain(input logic [7:0] c);
      string marks;
      bit    hit;
      int    i;
      hit = 1'b0;
      case (cls)
        SAFE_USER:   marks = "!$&'()*+,;=";
        SAFE_HOST:   marks = "!$&'()*+,;=:";
        SAFE_PATH:   marks = "!$&'()*+,;=:@/";
        SAFE_QUERY:  marks = "!$&'()*+,;=:@/?";
        SAFE_OPTION: marks = "!$'()*+,;:@/?";
        default:     return 1'b0;
      endcase
      if (c == 8'h00) return 1'b1;
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
        return 1'b1;
      end
      marks = {marks, "-._~"};
      for (i = 0; i < marks.len(); i++) begin
        if (marks[i] == c) hit = 1'b1;
      end
      return hit;
    endfunction

    // Works out the result beats of one accepted input beat.
    function void take_source_byte(input logic [7:0] b, input logic last);
      logic [7:0] grp[$];
      logic [3:0] hi;
      logic [3:0] lo;
      string      hexdig;
      hexdig = "0123456789ABCDEF";
      beats_in++;
      if (dir == DIR_ENCODE) begin
        if (passes_plain(b)) begin
          grp.push_back(b);
        end else begin
          grp.push_back(CHAR_PCT);
          grp.push_back(hexdig[b[7:4]]);
          grp.push_back(hexdig[b[3:0]]);
        end
      end else begin
        case (pend)
          PEND_PCT: begin
            if (last) begin
              grp.push_back(CHAR_PCT);
              grp.push_back(b);
              pend = PEND_IDLE;
              held = 8'h00;
            end else begin
              held = b;
              pend = PEND_DIGIT;
            end
          end
          PEND_DIGIT: begin
            if (hex_nibble(held, hi) && hex_nibble(b, lo)) begin
              grp.push_back({hi, lo});
            end else begin
              grp.push_back(CHAR_PCT);
              grp.push_back(held);
              grp.push_back(b);
            end
            pend = PEND_IDLE;
            held = 8'h00;
          end
          default: begin
            pend = PEND_IDLE;
            if (b == CHAR_PCT) begin
              if (last) grp.push_back(CHAR_PCT);
              else pend = PEND_PCT;
            end else begin
              grp.push_back(b);
            end
          end
        endcase
      end
      foreach (grp[i]) begin
        expected_chars.push_back({grp[i], last && (i == grp.size() - 1)});
      end
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    task check_output_byte(input logic [7:0] b, input logic last);
      char_beat_t want;
      beats_out++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("result beat %02h last %0b with nothing expected", b, last));
        return;
      end
      want = expected_chars.pop_front();
      if (b !== want.data) begin
        report_mismatch($sformatf("out_byte %02h, expected %02h", b, want.data));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h",
                                  last, want.last, want.data));
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = REG_DIRECTION;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          in_byte_i   = 8'h00;
  logic                in_last_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                out_last_o;

  codec_scoreboard codec_sb;
  bit              hold_request = 1'b0;
  int unsigned     burst_left   = 0;

  uri_percent_codec_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: ready follows a mode that changes at random intervals, and
  // on request it holds off for a long stretch so the block backs up.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      codec_sb.check_output_byte(out_byte_o, out_last_o);
    end
  end

  // Offers one input beat and waits for it to be taken. The sender works in
  // bursts; between bursts valid may drop for a random gap.
  task automatic send_item(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    codec_sb.take_source_byte(b, last);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Sends a whole string, marking its final byte.
  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  function automatic byte_q_t text_bytes(input string s);
    byte_q_t q;
    int      i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Writes one register; the extra wait keeps back-to-back writes apart.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    codec_sb.apply_setting(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every expected beat has come, then lets the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (codec_sb.expected_chars.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Builds a random string. About half the decode items are well-formed escapes,
  // the rest plain bytes and broken escapes, with at times a '%' cut off by the end.
  function automatic byte_q_t random_string(input logic dir);
    byte_q_t q;
    string   hexset;
    string   marks;
    hexset = "0123456789abcdefABCDEF";
    marks  = "!$&'()*+,;=:@/?-._~%# ";
    repeat ($urandom_range(1, 6)) begin
      if (dir == DIR_DECODE) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            q.push_back(CHAR_PCT);
            q.push_back(hexset[$urandom_range(0, hexset.len() - 1)]);
            q.push_back(hexset[$urandom_range(0, hexset.len() - 1)]);
          end
          5, 6: q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
          7:    q.push_back(8'($urandom_range(0, 255)));
          8: begin
            q.push_back(CHAR_PCT);
            q.push_back(8'($urandom_range(0, 255)));
            q.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            q.push_back(CHAR_PCT);
            q.push_back(hexset[$urandom_range(0, hexset.len() - 1)]);
            q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
          end
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
          1:       q.push_back(8'h61 + 8'($urandom_range(0, 25)));
          2:       q.push_back(8'h41 + 8'($urandom_range(0, 25)));
          default: q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    if (dir == DIR_DECODE && $urandom_range(0, 7) == 0) begin
      q.push_back(CHAR_PCT);
      if ($urandom_range(0, 1) == 1) q.push_back(hexset[$urandom_range(0, hexset.len() - 1)]);
    end
    return q;
  endfunction

  // Main sequence: reset, directed strings, then random phases.
  initial begin
    logic [3:0]          phase_plan [PHASE_COUNT];
    logic [CfgDataW-1:0] dir_word;
    byte_q_t             str;
    int unsigned         phase_items;
    int                  p;

    codec_sb   = new();
    phase_plan = '{{DIR_ENCODE, SAFE_USER},   {DIR_DECODE, SAFE_NONE},
                   {DIR_ENCODE, SAFE_HOST},   {DIR_ENCODE, SAFE_PATH},
                   {DIR_DECODE, SAFE_SPARE7}, {DIR_ENCODE, SAFE_QUERY},
                   {DIR_ENCODE, SAFE_OPTION}, {DIR_ENCODE, SAFE_SPARE6},
                   {DIR_ENCODE, SAFE_SPARE7}, {DIR_DECODE, SAFE_OPTION},
                   {DIR_ENCODE, SAFE_NONE},   {DIR_DECODE, SAFE_USER}};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Decode: plain-digit and lower-case escapes, a bad escape, a '%' inside a bad
    // escape, the byte extremes, and a '%' with no room after it.
    send_bytes(text_bytes("%41%6f%Zz%%41"));
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_PCT, 1'b1);
    send_bytes(text_bytes("%4"));

    // A direction write drops the half-read escape "%4".
    send_item(CHAR_PCT, 1'b0);
    send_item("4", 1'b0);
    settle();
    write_reg(REG_DIRECTION, CfgDataW'(DIR_DECODE));
    send_item("1", 1'b1);

    // Encode with the empty set, then byte 0 and the option set.
    settle();
    write_reg(REG_DIRECTION, CfgDataW'(DIR_ENCODE));
    send_item("a", 1'b0);
    send_item(8'h00, 1'b1);
    settle();
    write_reg(REG_SAFE_CLASS, SAFE_OPTION);
    send_bytes(text_bytes("&~"));
    send_item(8'h00, 1'b1);

    // Random phases, each under its own register setting. The receiver
    // holds off for a long stretch at the start of the first one.
    for (p = 0; p < PHASE_COUNT; p++) begin
      settle();
      dir_word    = CfgDataW'($urandom_range(0, 7));
      dir_word[0] = phase_plan[p][3];
      write_reg(REG_SAFE_CLASS, phase_plan[p][2:0]);
      write_reg(REG_DIRECTION, dir_word);
      if (p == 0) hold_request = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        str = random_string(phase_plan[p][3]);
        send_bytes(str);
        phase_items += str.size();
      end
    end

    settle();
    if (codec_sb.expected_chars.size() != 0) begin
      codec_sb.report_mismatch($sformatf("%0d result beats never arrived",
                                         codec_sb.expected_chars.size()));
    end
    $display("Run covered %0d input beats and %0d result beats after %0d register writes,",
             codec_sb.beats_in, codec_sb.beats_out, codec_sb.writes);
    $display("in decode and encode mode over safe classes 0 to 7 with stalls on both sides.");
    if (codec_sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout: the run did not finish in time.");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
